[hw/rtl/lsac_pkg.sv]
`timescale 1ns / 1ps
package lsac_pkg;

    localparam int LOG_SETS_DEF    = 10;
    localparam int WAYS_DEF        = 2;
    localparam int COUNT_WIDTH_DEF = 48;
    localparam int SET_W_MAX       = 16;
    localparam int OUT_CNT_W       = 48;

    localparam logic [1:0] MODE_PIPT = 2'd0;
    localparam logic [1:0] MODE_VIPT = 2'd1;
    localparam logic [1:0] MODE_VIVT = 2'd2;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_LOG_PAGE  = 2'd1;
    localparam logic [1:0] REG_LOG_PHYS  = 2'd2;
    localparam logic [1:0] REG_LOG_BLOCK = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] log_page;
        logic [5:0] log_phys;
        logic [3:0] log_block;
    } t_cfg;

    typedef struct packed {
        logic                 action;
        logic [SET_W_MAX-1:0] set;
        logic [31:0]          tag;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic [2:0]           way_used;
        logic                 evicted_valid;
        logic [9:0]           set_index;
        logic [31:0]          line_tag;
        logic [OUT_CNT_W-1:0] read_requests;
        logic [OUT_CNT_W-1:0] write_requests;
        logic [OUT_CNT_W-1:0] read_hits;
        logic [OUT_CNT_W-1:0] write_hits;
    } t_rsp;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_LOOK
    } t_bstate;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
        asr32 = $unsigned($signed(v) >>> s);
    endfunction

    // first three mixing steps of the page hash
    function automatic logic [31:0] hash_head(input logic [31:0] k0);
        logic [31:0] k1;
        logic [31:0] k2;
        k1 = ~k0 + (k0 << 15);
        k2 = k1 ^ asr32(k1, 12);
        hash_head = k2 + (k2 << 2);
    endfunction

    // remaining steps, then keep the configured number of bits
    function automatic logic [31:0] hash_tail(input logic [31:0] k3, input logic [5:0] bits);
        logic [31:0] k4;
        logic [31:0] k5;
        logic [31:0] k6;
        logic [5:0]  nb;
        logic [63:0] mask;
        k4   = k3 ^ asr32(k3, 4);
        k5   = k4 + (k4 << 3) + (k4 << 11);
        k6   = k5 ^ asr32(k5, 16);
        nb   = (bits > 6'd32) ? 6'd32 : bits;
        mask = (64'd1 << nb) - 64'd1;
        hash_tail = k6 & mask[31:0];
    endfunction

endpackage

[hw/rtl/lsac_ram.sv]
`timescale 1ns / 1ps
module lsac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/lsac_fifo.sv]
`timescale 1ns / 1ps
module lsac_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_data;
        end
    end
endmodule

[hw/rtl/lsac_front.sv]
`timescale 1ns / 1ps
module lsac_front #(
    parameter int LOG_SETS = lsac_pkg::LOG_SETS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lsac_pkg::t_cfg   i_cfg,
    input  logic             i_blocked,
    input  logic             i_push,
    input  logic             i_action,
    input  logic [31:0]      i_virtual_address,
    output logic             o_full,
    input  logic             i_q_full,
    output logic             o_q_push,
    output lsac_pkg::t_req   o_q_data
);
    import lsac_pkg::*;

    logic        r_s1_v, r_s2_v;
    logic        r_s1_act, r_s2_act;
    logic [31:0] r_s1_va, r_s2_va;
    logic [31:0] r_s2_k;
    logic        adv, acc;
    logic [31:0] vpn, n_k;
    logic [31:0] phash, off_mask32;
    logic [63:0] off_mask, pa, set_src, tag_src, set_sh, tag_sh;
    logic [6:0]  tshift;

    assign adv    = !(r_s2_v && i_q_full);
    assign o_full = i_blocked || (r_s1_v && !adv);
    assign acc    = i_push && !o_full;

    assign vpn = r_s1_va >> i_cfg.log_page;
    assign n_k = hash_head(vpn);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (adv) begin
                r_s2_v <= r_s1_v;
            end
            if (adv || !r_s1_v) begin
                r_s1_v <= acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_act <= r_s1_act;
            r_s2_va  <= r_s1_va;
            r_s2_k   <= n_k;
        end
        if (adv || !r_s1_v) begin
            r_s1_act <= i_action;
            r_s1_va  <= i_virtual_address;
        end
    end

    // physical address and set/tag split
    always_comb begin
        phash      = hash_tail(r_s2_k, i_cfg.log_phys);
        off_mask   = (64'd1 << i_cfg.log_page) - 64'd1;
        off_mask32 = off_mask[31:0];
        pa         = ({32'd0, phash} << i_cfg.log_page) | {32'd0, r_s2_va & off_mask32};
        set_src    = (i_cfg.mode == MODE_PIPT) ? pa : {32'd0, r_s2_va};
        tag_src    = (i_cfg.mode == MODE_PIPT || i_cfg.mode == MODE_VIPT) ?
                     pa : {32'd0, r_s2_va};
        tshift     = 7'(i_cfg.log_block) + 7'(LOG_SETS);
        set_sh     = set_src >> i_cfg.log_block;
        tag_sh     = tag_src >> tshift;
        o_q_data.action = r_s2_act;
        o_q_data.set    = set_sh[SET_W_MAX-1:0];
        o_q_data.tag    = tag_sh[31:0];
    end

    assign o_q_push = r_s2_v && !i_q_full;
endmodule

[hw/rtl/lsac_back.sv]
`timescale 1ns / 1ps
module lsac_back #(
    parameter int LOG_SETS    = lsac_pkg::LOG_SETS_DEF,
    parameter int WAYS        = lsac_pkg::WAYS_DEF,
    parameter int COUNT_WIDTH = lsac_pkg::COUNT_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  lsac_pkg::t_req i_q_data,
    output logic           o_q_pop,
    input  logic           i_out_full,
    output logic           o_out_push,
    output lsac_pkg::t_rsp o_out_data,
    output logic           o_clearing
);
    import lsac_pkg::*;

    localparam int AW       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NSETS    = 1 << LOG_SETS;
    localparam int TAG_BITS = WAYS * 32;
    localparam int AGE_BITS = WAYS * AW;
    localparam int RW       = TAG_BITS + AGE_BITS + WAYS;

    t_bstate                r_state, n_state;
    logic [LOG_SETS-1:0]    r_clr_addr;
    logic                   r_act;
    logic [LOG_SETS-1:0]    r_set;
    logic [31:0]            r_tag;
    logic [COUNT_WIDTH-1:0] r_rd_req, r_wr_req, r_rd_hit, r_wr_hit;
    logic [COUNT_WIDTH-1:0] n_rd_req, n_wr_req, n_rd_hit, n_wr_hit;

    logic                   ram_we;
    logic [LOG_SETS-1:0]    ram_waddr, ram_raddr;
    logic [RW-1:0]          ram_wdata, ram_rdata, new_row;
    logic                   start;

    logic [31:0]            tags [WAYS];
    logic [AW-1:0]          ages [WAYS];
    logic [WAYS-1:0]        vld;
    logic                   hit_f, emp_f;
    logic [AW-1:0]          hit_w, emp_w, lru_w, max_r, used;
    logic [AW:0]            nvalid, old;
    logic                   evicted;
    logic [63:0]            c_rr, c_wr, c_rh, c_wh;
    logic [15:0]            set16;

    lsac_ram #(.WIDTH(RW), .DEPTH(NSETS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign start = (r_state == BS_IDLE) && !i_q_empty && !i_out_full;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_CLEAR: begin
                if (r_clr_addr == LOG_SETS'(NSETS - 1)) n_state = BS_IDLE;
            end
            BS_IDLE: begin
                if (start) n_state = BS_LOOK;
            end
            BS_LOOK: n_state = BS_IDLE;
            default: n_state = BS_CLEAR;
        endcase
    end

    always_comb begin
        o_clearing = 1'b0;
        o_q_pop    = 1'b0;
        o_out_push = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_set;
        ram_wdata  = new_row;
        case (r_state)
            BS_CLEAR: begin
                o_clearing = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
            end
            BS_IDLE: o_q_pop = start;
            BS_LOOK: begin
                ram_we     = 1'b1;
                o_out_push = 1'b1;
            end
            default: o_clearing = 1'b1;
        endcase
    end

    assign ram_raddr = i_q_data.set[LOG_SETS-1:0];

    // tag compare, victim choice and recency update of one set
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            tags[w] = ram_rdata[w*32 +: 32];
            ages[w] = ram_rdata[TAG_BITS + w*AW +: AW];
            vld[w]  = ram_rdata[TAG_BITS + AGE_BITS + w];
        end
        hit_f  = 1'b0;
        hit_w  = '0;
        emp_f  = 1'b0;
        emp_w  = '0;
        lru_w  = '0;
        max_r  = '0;
        nvalid = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (vld[w]) begin
                nvalid = nvalid + (AW+1)'(1);
                if (!hit_f && tags[w] == r_tag) begin
                    hit_f = 1'b1;
                    hit_w = AW'(w);
                end
                if (ages[w] >= max_r) begin
                    if (ages[w] > max_r || lru_w == '0) lru_w = AW'(w);
                    max_r = ages[w];
                end
            end else begin
                emp_f = 1'b1;
                emp_w = AW'(w);
            end
        end
        used    = hit_f ? hit_w : (emp_f ? emp_w : lru_w);
        evicted = !hit_f && vld[used];
        old     = vld[used] ? {1'b0, ages[used]} : nvalid;
        new_row = ram_rdata;
        for (int w = 0; w < WAYS; w++) begin
            if (AW'(w) == used) begin
                new_row[TAG_BITS + w*AW +: AW] = '0;
                if (!hit_f) begin
                    new_row[TAG_BITS + AGE_BITS + w] = 1'b1;
                    new_row[w*32 +: 32]              = r_tag;
                end
            end else if (vld[w] && {1'b0, ages[w]} < old) begin
                new_row[TAG_BITS + w*AW +: AW] = ages[w] + AW'(1);
            end
        end
    end

    always_comb begin
        n_rd_req = r_rd_req;
        n_wr_req = r_wr_req;
        n_rd_hit = r_rd_hit;
        n_wr_hit = r_wr_hit;
        if (r_act) begin
            n_wr_req = r_wr_req + COUNT_WIDTH'(1);
            if (hit_f) n_wr_hit = r_wr_hit + COUNT_WIDTH'(1);
        end else begin
            n_rd_req = r_rd_req + COUNT_WIDTH'(1);
            if (hit_f) n_rd_hit = r_rd_hit + COUNT_WIDTH'(1);
        end
        c_rr  = 64'(n_rd_req);
        c_wr  = 64'(n_wr_req);
        c_rh  = 64'(n_rd_hit);
        c_wh  = 64'(n_wr_hit);
        set16 = 16'(r_set);
        o_out_data.hit            = hit_f;
        o_out_data.way_used       = 3'(used);
        o_out_data.evicted_valid  = evicted;
        o_out_data.set_index      = set16[9:0];
        o_out_data.line_tag       = r_tag;
        o_out_data.read_requests  = c_rr[OUT_CNT_W-1:0];
        o_out_data.write_requests = c_wr[OUT_CNT_W-1:0];
        o_out_data.read_hits      = c_rh[OUT_CNT_W-1:0];
        o_out_data.write_hits     = c_wh[OUT_CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_CLEAR;
            r_clr_addr <= '0;
            r_rd_req   <= '0;
            r_wr_req   <= '0;
            r_rd_hit   <= '0;
            r_wr_hit   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BS_CLEAR) r_clr_addr <= r_clr_addr + LOG_SETS'(1);
            if (r_state == BS_LOOK) begin
                r_rd_req <= n_rd_req;
                r_wr_req <= n_wr_req;
                r_rd_hit <= n_rd_hit;
                r_wr_hit <= n_wr_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_act <= i_q_data.action;
            r_set <= i_q_data.set[LOG_SETS-1:0];
            r_tag <= i_q_data.tag;
        end
    end
endmodule

[hw/rtl/lru_set_assoc_cache_tag_model.sv]
`timescale 1ns / 1ps
// Set-associative tag array with true LRU replacement.
// Request channel: push/full with i_action (0 read, 1 write) and
// i_virtual_address; a request is taken when push is high and full is low.
// Result channel: empty/pop; the oldest result sits on the o_ ports while
// empty is low and leaves when pop is high.
// Configuration: APB write of addressing mode, page, memory and block size
// at byte offsets 0, 4, 8, 12; pready is always high. Write only when idle.
// Each request gives exactly one result: hit, way, eviction, set, tag and
// the four running counters after this access.
// Requests pass the front hash stages and the request queue to the lookup,
// which takes no new request until the last one's set row in the tag
// memory is read (registered), compared, updated and written back.
// The front hash pipeline and a 2-entry request queue run ahead of it.
// After reset the tag memory is swept clear, one set per cycle, all
// 2^LOG_SETS sets, while full stays high; config writes are taken meanwhile.
// When pop stays low, a 2-entry result queue fills, then the lookup stalls,
// then the request queue and front fill and full rises.
module lru_set_assoc_cache_tag_model #(
    parameter int LOG_SETS    = lsac_pkg::LOG_SETS_DEF,
    parameter int WAYS        = lsac_pkg::WAYS_DEF,
    parameter int COUNT_WIDTH = lsac_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [31:0] i_virtual_address,
    output logic        empty,
    input  logic        pop,
    output logic        o_hit,
    output logic [2:0]  o_way_used,
    output logic        o_evicted_valid,
    output logic [9:0]  o_set_index,
    output logic [31:0] o_line_tag,
    output logic [47:0] o_read_requests,
    output logic [47:0] o_write_requests,
    output logic [47:0] o_read_hits,
    output logic [47:0] o_write_hits
);
    import lsac_pkg::*;

    t_cfg r_cfg;
    t_req q_in, q_out;
    t_rsp rsp_in, rsp_out;
    logic q_push, q_pop, q_full, q_empty;
    logic out_push, out_full, clearing;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_PIPT;
            r_cfg.log_page  <= 5'd12;
            r_cfg.log_phys  <= 6'd16;
            r_cfg.log_block <= 4'd5;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:      r_cfg.mode      <= pwdata[1:0];
                REG_LOG_PAGE:  r_cfg.log_page  <= pwdata[4:0];
                REG_LOG_PHYS:  r_cfg.log_phys  <= pwdata[5:0];
                REG_LOG_BLOCK: r_cfg.log_block <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODE:      prdata = {30'd0, r_cfg.mode};
            REG_LOG_PAGE:  prdata = {27'd0, r_cfg.log_page};
            REG_LOG_PHYS:  prdata = {26'd0, r_cfg.log_phys};
            REG_LOG_BLOCK: prdata = {28'd0, r_cfg.log_block};
            default:       prdata = '0;
        endcase
    end

    lsac_front #(.LOG_SETS(LOG_SETS)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_blocked        (clearing),
        .i_push           (push),
        .i_action         (i_action),
        .i_virtual_address(i_virtual_address),
        .o_full           (full),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_q_data         (q_in)
    );

    lsac_fifo #(.WIDTH($bits(t_req)), .DEPTH(2)) u_req_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    lsac_back #(
        .LOG_SETS   (LOG_SETS),
        .WAYS       (WAYS),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .i_out_full(out_full),
        .o_out_push(out_push),
        .o_out_data(rsp_in),
        .o_clearing(clearing)
    );

    lsac_fifo #(.WIDTH($bits(t_rsp)), .DEPTH(2)) u_rsp_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data (rsp_in),
        .i_pop  (pop),
        .o_data (rsp_out),
        .o_full (out_full),
        .o_empty(empty)
    );

    assign o_hit            = rsp_out.hit;
    assign o_way_used       = rsp_out.way_used;
    assign o_evicted_valid  = rsp_out.evicted_valid;
    assign o_set_index      = rsp_out.set_index;
    assign o_line_tag       = rsp_out.line_tag;
    assign o_read_requests  = rsp_out.read_requests;
    assign o_write_requests = rsp_out.write_requests;
    assign o_read_hits      = rsp_out.read_hits;
    assign o_write_hits     = rsp_out.write_hits;
endmodule

[hw/rtl/lsac_checker.sv]
`timescale 1ns / 1ps
module lsac_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_hit,
    input logic        o_evicted_valid,
    input logic [31:0] o_line_tag
);
    // the clearing sweep blocks requests right after reset
    a_full_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("request port open right after reset");

    a_empty_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present right after reset");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !(o_hit && o_evicted_valid))
        else $error("hit reported with an eviction");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_line_tag)))
        else $error("stalled result changed");
endmodule

bind lru_set_assoc_cache_tag_model lsac_checker u_lsac_checker (.*);
